>>> rtl/dip_pkg.sv
// shared types, character codes and limits for the dotted ipv4 address parser
package dip_pkg;

    // parse phase
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ZERO  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_SKIP  = 3'd3
    } phase_t;

    // radix of the current part
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // largest value of the last part for two, three and four parts
    localparam logic [31:0] LIMIT_TWO   = 32'h00FF_FFFF;
    localparam logic [31:0] LIMIT_THREE = 32'h0000_FFFF;
    localparam logic [31:0] LIMIT_FOUR  = 32'h0000_00FF;

    // parser state
    typedef struct packed {
        phase_t           phase;
        logic [31:0]      number_value;
        radix_t           radix_code;
        logic [2:0][31:0] stored_parts;
        logic [1:0]       parts_seen;
    } dip_state_t;

    // one result item from the step logic
    typedef struct packed {
        logic        fire;
        logic        ok;
        logic [31:0] addr;
    } dip_result_t;

    // state at the start of a fresh parse
    function automatic dip_state_t dip_cleared();
        dip_state_t s;
        s.phase        = PH_START;
        s.number_value = '0;
        s.radix_code   = RX_DEC;
        s.stored_parts = '0;
        s.parts_seen   = '0;
        return s;
    endfunction

endpackage

>>> rtl/dotted_ipv4_address_parser.sv
// dotted ipv4 address parser, top level
// the character that decides a result is first taken into the character register; the result is then registered from it
// throughput: one character per cycle; the only stall comes from a held result
// the parse of each character is one pass of logic between the character and result registers
// reset: asynchronous, active low; clears the parse state and both valid flags
module dotted_ipv4_address_parser
    import dip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        address_ok,
    output logic [31:0] address
);

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    dip_state_t  state_reg;
    dip_state_t  state_next;
    dip_result_t step_res;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [31:0] addr_reg;
    logic        advance;
    logic        in_take;

    // handshake
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // parse step
    dip_step u_step (
        .cur       (state_reg),
        .text_char (char_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= dip_cleared();
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg <= state_next;
            end

            if (advance && step_res.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= text_char;
        end
        if (advance && step_res.fire)
        begin
            ok_reg   <= step_res.ok;
            addr_reg <= step_res.addr;
        end
    end

    assign out_valid  = out_valid_reg;
    assign address_ok = ok_reg;
    assign address    = addr_reg;

endmodule

>>> rtl/dip_step.sv
// next-state and result logic for one character of the address parser
module dip_step
    import dip_pkg::*;
(
    input  dip_state_t  cur,
    input  logic [7:0]  text_char,
    output dip_state_t  nxt,
    output dip_result_t res
);

    logic        is_dec;
    logic        is_blank;
    logic        is_lower_hex;
    logic        is_upper_hex;
    logic        is_x;
    logic        do_digit;
    radix_t      eff_radix;
    logic [3:0]  letter_val;
    logic [31:0] times_ten;
    logic [31:0] scaled;
    logic [31:0] nv;
    logic        emit_req;
    logic        emit_ok;
    logic [31:0] emit_addr;

    // character classes
    assign is_dec       = (text_char >= CH_0) && (text_char <= CH_9);
    assign is_blank     = (text_char == CH_SPACE) ||
                          ((text_char >= CH_TAB) && (text_char <= CH_CR));
    assign is_lower_hex = (text_char >= CH_LA) && (text_char <= CH_LF);
    assign is_upper_hex = (text_char >= CH_UA) && (text_char <= CH_UF);
    assign is_x         = (text_char == CH_LX) || (text_char == CH_UX);
    assign letter_val   = {1'b0, text_char[2:0]} + 4'd9;

    // a part that began with zero and no x is octal from this character on
    assign eff_radix = (cur.phase == PH_ZERO) ? RX_OCT : cur.radix_code;
    assign do_digit  = (cur.phase == PH_DIGIT) || ((cur.phase == PH_ZERO) && !is_x);

    // value times the radix, by shifts and one add
    assign times_ten = {cur.number_value[28:0], 3'b000} + {cur.number_value[30:0], 1'b0};
    always_comb
    begin
        case (eff_radix)
            RX_OCT:  scaled = {cur.number_value[28:0], 3'b000};
            RX_HEX:  scaled = {cur.number_value[27:0], 4'b0000};
            default: scaled = times_ten;
        endcase
    end

    // main transition
    always_comb
    begin
        nxt       = cur;
        emit_req  = 1'b0;
        emit_ok   = 1'b0;
        emit_addr = '0;
        nv        = cur.number_value;
        case (cur.phase)
            PH_START:
            begin
                if (!is_dec)
                begin
                    emit_req = 1'b1;
                end
                else if (text_char == CH_0)
                begin
                    nxt.number_value = '0;
                    nxt.phase        = PH_ZERO;
                end
                else
                begin
                    nxt.radix_code   = RX_DEC;
                    nxt.number_value = {28'd0, text_char[3:0]};
                    nxt.phase        = PH_DIGIT;
                end
            end
            PH_ZERO, PH_DIGIT:
            begin
                nxt.phase = PH_DIGIT;
                if (!do_digit)
                begin
                    // 0x or 0X prefix
                    nxt.radix_code = RX_HEX;
                end
                else
                begin
                    nxt.radix_code = eff_radix;
                    if (is_dec)
                    begin
                        nxt.number_value = scaled + {28'd0, text_char[3:0]};
                    end
                    else if ((eff_radix == RX_HEX) && (is_lower_hex || is_upper_hex))
                    begin
                        nxt.number_value = {cur.number_value[27:0], letter_val};
                    end
                    else if (text_char == CH_DOT)
                    begin
                        if (cur.parts_seen == 2'd3)
                        begin
                            // a fourth dot
                            emit_req = 1'b1;
                        end
                        else
                        begin
                            nxt.stored_parts[cur.parts_seen] = cur.number_value;
                            nxt.parts_seen   = cur.parts_seen + 2'd1;
                            nxt.number_value = '0;
                            nxt.radix_code   = RX_DEC;
                            nxt.phase        = PH_START;
                        end
                    end
                    else if ((text_char == CH_NUL) || is_blank)
                    begin
                        // end of string: range check the last part and assemble
                        emit_req = 1'b1;
                        emit_ok  = 1'b1;
                        case (cur.parts_seen)
                            2'd1:
                            begin
                                emit_ok   = (nv <= LIMIT_TWO);
                                emit_addr = nv | {cur.stored_parts[0][7:0], 24'd0};
                            end
                            2'd2:
                            begin
                                emit_ok   = (nv <= LIMIT_THREE);
                                emit_addr = nv | {cur.stored_parts[0][7:0], 24'd0}
                                               | {cur.stored_parts[1][15:0], 16'd0};
                            end
                            2'd3:
                            begin
                                emit_ok   = (nv <= LIMIT_FOUR);
                                emit_addr = nv | {cur.stored_parts[0][7:0], 24'd0}
                                               | {cur.stored_parts[1][15:0], 16'd0}
                                               | {cur.stored_parts[2][23:0], 8'd0};
                            end
                            default:
                            begin
                                emit_addr = nv;
                            end
                        endcase
                    end
                    else
                    begin
                        emit_req = 1'b1;
                    end
                end
            end
            default:
            begin
                // skipping up to the zero byte
                if (text_char == CH_NUL)
                begin
                    nxt = dip_cleared();
                end
            end
        endcase

        // a result restarts the parse, or skips to the zero byte
        if (emit_req)
        begin
            nxt = dip_cleared();
            if (text_char != CH_NUL)
            begin
                nxt.phase = PH_SKIP;
            end
        end
    end

    // result item
    assign res.fire = emit_req;
    assign res.ok   = emit_ok;
    assign res.addr = emit_ok ? emit_addr : '1;

endmodule

>>> rtl/dip_checker.sv
// port checks for the dotted ipv4 address parser, bound to the top level
module dip_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  text_char,
    input logic        out_valid,
    input logic        out_stall,
    input logic        address_ok,
    input logic [31:0] address
);

    // a held result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(address) && $stable(address_ok))
        else $error("result changed while stalled");

    // a failed parse reports all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !address_ok |-> address == 32'hFFFF_FFFF)
        else $error("failed result without all-ones address");

    // input only backs up behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // a stalled input item is held unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(text_char))
        else $error("input item changed while stalled");

endmodule

bind dotted_ipv4_address_parser dip_checker u_dip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_char  (text_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .address_ok (address_ok),
    .address    (address)
);
